>>> rtl/ppp_pkg.sv
// Package for the perspective point projector.
// Register indexes, field widths, reset values and parameter defaults.
// No dependencies.
package ppp_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  localparam int TRIG_W     = 16;
  localparam int RHO_W      = 16;
  localparam int DIST_W     = 12;
  localparam int OFF_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SIN_AZ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_AZ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_EL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_EL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EYE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_Y   = 3'd7;

  localparam logic [TRIG_W-1:0] RST_SIN_AZ = 16'd11585;
  localparam logic [TRIG_W-1:0] RST_COS_AZ = 16'd11585;
  localparam logic [TRIG_W-1:0] RST_SIN_EL = 16'd14116;
  localparam logic [TRIG_W-1:0] RST_COS_EL = 16'd8318;
  localparam logic [RHO_W-1:0]  RST_EYE    = 16'd492;
  localparam logic [DIST_W-1:0] RST_PROJ   = 12'd200;
  localparam logic [OFF_W-1:0]  RST_OFF_X  = 16'd320;
  localparam logic [OFF_W-1:0]  RST_OFF_Y  = 16'd320;

endpackage

>>> rtl/ppp_if.sv
// Channel interfaces of the perspective point projector.
// Depends on ppp_pkg.
interface ppp_in_if #(parameter int COORD_BITS = ppp_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_out_if #(parameter int COORD_BITS = ppp_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] screen_x;
  logic signed [COORD_BITS-1:0] screen_y;
  logic                         depth_zero;
  modport source (output valid, screen_x, screen_y, depth_zero, input ready);
  modport sink   (input valid, screen_x, screen_y, depth_zero, output ready);
endinterface

interface ppp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ppp_pkg::CFG_IDX_W-1:0]       index;
  logic [ppp_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/ppp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Truncates toward zero; zero_i selects the alternate value. No package use.
module ppp_divider #(
  parameter int NUM_W = 67,
  parameter int DEN_W = 50,
  parameter int OUT_W = 16
) (
  input  logic                    clk_i,
  input  logic [OUT_W+3:0]        en_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  input  logic                    zero_i,
  input  logic [OUT_W-1:0]        alt_i,
  output logic [OUT_W-1:0]        quo_o,
  output logic                    zero_o
);
  localparam int QB = OUT_W + 1;
  localparam int RW = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
  localparam logic [QB-1:0] LO = QB'(1) << (OUT_W - 1);
  localparam logic [QB-1:0] HI = LO - QB'(1);

  // stage 0: magnitudes
  logic [NUM_W-1:0] mn_q;
  logic [DEN_W-1:0] md0_q;
  logic             neg0_q, zero0_q;
  logic [OUT_W-1:0] alt0_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mn_q    <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      md0_q   <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      neg0_q  <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      zero0_q <= zero_i;
      alt0_q  <= alt_i;
    end
  end

  // stage 1 fills index 0, iteration k fills index k+1
  logic [RW-1:0]    r_q    [QB+1];
  logic [QB-1:0]    qv_q   [QB+1];
  logic [DEN_W-1:0] md_q   [QB+1];
  logic             neg_q  [QB+1];
  logic             ovf_q  [QB+1];
  logic             zr_q   [QB+1];
  logic [OUT_W-1:0] alt_q  [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      r_q[0]   <= RW'(mn_q);
      qv_q[0]  <= '0;
      md_q[0]  <= md0_q;
      neg_q[0] <= neg0_q;
      ovf_q[0] <= RW'(mn_q >> QB) >= RW'(md0_q);
      zr_q[0]  <= zero0_q;
      alt_q[0] <= alt0_q;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_iter
    localparam int BIT = QB - 1 - k;
    logic [RW-1:0] t;
    logic          ge;
    assign t  = RW'(md_q[k]) << BIT;
    assign ge = r_q[k] >= t;
    always_ff @(posedge clk_i) begin
      if (en_i[k+2]) begin
        r_q[k+1]       <= ge ? r_q[k] - t : r_q[k];
        qv_q[k+1]      <= qv_q[k] | (QB'(ge) << BIT);
        md_q[k+1]      <= md_q[k];
        neg_q[k+1]     <= neg_q[k];
        ovf_q[k+1]     <= ovf_q[k];
        zr_q[k+1]      <= zr_q[k];
        alt_q[k+1]     <= alt_q[k];
      end
    end
  end

  logic [OUT_W-1:0] sat;
  logic [QB-1:0]    q;
  always_comb begin
    q = qv_q[QB];
    if (neg_q[QB]) begin
      if (ovf_q[QB] || q > LO) sat = OUT_W'(LO);
      else                     sat = OUT_W'(-q);
    end else begin
      if (ovf_q[QB] || q > HI) sat = OUT_W'(HI);
      else                     sat = OUT_W'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[QB+2]) begin
      quo_o  <= zr_q[QB] ? alt_q[QB] : sat;
      zero_o <= zr_q[QB];
    end
  end

endmodule

>>> rtl/perspective_point_projector_unit.sv
// Perspective point projector: spherical-camera viewing transform and projection.
// Depends on ppp_pkg, ppp_if and ppp_divider.
//
// Usage:
//   in_i   takes one world point (point_x, point_y, point_z) per transaction.
//   out_o  gives one result per point: screen_x, screen_y, depth_zero.
//   cfg_i  writes one of eight registers (index 0..7); always ready. Write only
//          while no point is in flight.
// Throughput: one point per cycle unless out_o stalls, set by a fully pipelined
//   datapath whose divider resolves one quotient bit per stage.
// Each stage holds its item until the next stage frees up, so bubbles collapse
//   and a stalled receiver backs the pipeline up stage by stage; in_i drops
//   ready only when every stage is full. Nothing is lost or repeated.
// Zero view depth sets depth_zero and returns the screen offsets.
// Reset: pipeline empties, registers take their reset values.
module perspective_point_projector_unit #(
  parameter int COORD_BITS     = ppp_pkg::COORD_BITS_DEF,
  parameter int TRIG_FRAC_BITS = ppp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ppp_cfg_if.sink  cfg_i,
  ppp_in_if.sink   in_i,
  ppp_out_if.source out_o
);
  import ppp_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int F     = TRIG_FRAC_BITS;
  localparam int W_TC  = TRIG_W + C;
  localparam int W_TT  = 2 * TRIG_W;
  localparam int W_TTC = 2 * TRIG_W + C;
  localparam int W_A   = (W_TTC > W_TC + F + 1) ? W_TTC : W_TC + F + 1;
  localparam int W_B   = (W_A > RHO_W + 1 + 2 * F) ? W_A : RHO_W + 1 + 2 * F;
  localparam int W_V   = W_B + 2;
  localparam int W_M   = W_V + OFF_W;
  localparam int W_N   = W_M + 1;
  localparam int W_O   = (C > OFF_W) ? C : OFF_W;
  localparam int DS    = C + 4;
  localparam int NS    = 5 + DS;
  localparam logic signed [W_O-1:0] OHI = W_O'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [W_O-1:0] OLO = W_O'(-(64'sd1 <<< (C - 1)));

  // configuration registers
  logic signed [TRIG_W-1:0] sa_q, ca_q, se_q, ce_q;
  logic        [RHO_W-1:0]  rho_q;
  logic        [DIST_W-1:0] dist_q;
  logic signed [OFF_W-1:0]  offx_q, offy_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q   <= RST_SIN_AZ;
      ca_q   <= RST_COS_AZ;
      se_q   <= RST_SIN_EL;
      ce_q   <= RST_COS_EL;
      rho_q  <= RST_EYE;
      dist_q <= RST_PROJ;
      offx_q <= RST_OFF_X;
      offy_q <= RST_OFF_Y;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SIN_AZ: sa_q   <= cfg_i.data;
        REG_COS_AZ: ca_q   <= cfg_i.data;
        REG_SIN_EL: se_q   <= cfg_i.data;
        REG_COS_EL: ce_q   <= cfg_i.data;
        REG_EYE:    rho_q  <= cfg_i.data;
        REG_PROJ:   dist_q <= cfg_i.data[DIST_W-1:0];
        REG_OFF_X:  offx_q <= cfg_i.data;
        REG_OFF_Y:  offy_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // stage 1: single products
  logic signed [W_TC-1:0] sax_q, cay_q, sez_q, cez_q;
  logic signed [W_TT-1:0] ceca_q, cesa_q, seca_q, sesa_q;
  logic signed [C-1:0]    x1_q, y1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sax_q  <= W_TC'(sa_q) * W_TC'(in_i.point_x);
      cay_q  <= W_TC'(ca_q) * W_TC'(in_i.point_y);
      sez_q  <= W_TC'(se_q) * W_TC'(in_i.point_z);
      cez_q  <= W_TC'(ce_q) * W_TC'(in_i.point_z);
      ceca_q <= W_TT'(ce_q) * W_TT'(ca_q);
      cesa_q <= W_TT'(ce_q) * W_TT'(sa_q);
      seca_q <= W_TT'(se_q) * W_TT'(ca_q);
      sesa_q <= W_TT'(se_q) * W_TT'(sa_q);
      x1_q   <= in_i.point_x;
      y1_q   <= in_i.point_y;
    end
  end

  // stage 2: double products, xv
  logic signed [W_TTC-1:0] ccx_q, csy_q, scx_q, ssy_q;
  logic signed [W_TC-1:0]  sez2_q, cez2_q;
  logic signed [W_V-1:0]   xv2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ccx_q  <= W_TTC'(ceca_q) * W_TTC'(x1_q);
      csy_q  <= W_TTC'(cesa_q) * W_TTC'(y1_q);
      scx_q  <= W_TTC'(seca_q) * W_TTC'(x1_q);
      ssy_q  <= W_TTC'(sesa_q) * W_TTC'(y1_q);
      xv2_q  <= (W_V'(cay_q) - W_V'(sax_q)) <<< F;
      sez2_q <= sez_q;
      cez2_q <= cez_q;
    end
  end

  // stage 3: yv, zv
  logic signed [W_V-1:0] xv3_q, yv3_q, zv3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      xv3_q <= xv2_q;
      yv3_q <= (W_V'(sez2_q) <<< F) - W_V'(ccx_q) - W_V'(csy_q);
      zv3_q <= (W_V'(rho_q) << (2 * F)) - W_V'(scx_q) - W_V'(ssy_q)
               - (W_V'(cez2_q) <<< F);
    end
  end

  // stage 4: scale by projection distance and offset
  logic signed [W_M-1:0] dx_q, dy_q, ox_q, oy_q;
  logic signed [W_V-1:0] zv4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dx_q  <= W_M'($signed({1'b0, dist_q})) * W_M'(xv3_q);
      dy_q  <= W_M'($signed({1'b0, dist_q})) * W_M'(yv3_q);
      ox_q  <= W_M'(offx_q) * W_M'(zv3_q);
      oy_q  <= W_M'(offy_q) * W_M'(zv3_q);
      zv4_q <= zv3_q;
    end
  end

  // stage 5: numerators, zero flag, saturated offsets
  logic signed [W_N-1:0] nx_q, ny_q;
  logic signed [W_V-1:0] zv5_q;
  logic                  zero5_q;
  logic [C-1:0]          altx_q, alty_q;
  logic signed [W_O-1:0] offx_e, offy_e;
  logic [C-1:0]          altx_d, alty_d;

  assign offx_e = W_O'(offx_q);
  assign offy_e = W_O'(offy_q);

  always_comb begin
    if (offx_e > OHI)      altx_d = C'(OHI);
    else if (offx_e < OLO) altx_d = C'(OLO);
    else                   altx_d = C'(offx_e);
    if (offy_e > OHI)      alty_d = C'(OHI);
    else if (offy_e < OLO) alty_d = C'(OLO);
    else                   alty_d = C'(offy_e);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      nx_q    <= W_N'(dx_q) + W_N'(ox_q);
      ny_q    <= W_N'(dy_q) + W_N'(oy_q);
      zv5_q   <= zv4_q;
      zero5_q <= (zv4_q == '0);
      altx_q  <= altx_d;
      alty_q  <= alty_d;
    end
  end

  logic [C-1:0] qx, qy;
  logic         zx, zy;

  ppp_divider #(.NUM_W(W_N), .DEN_W(W_V), .OUT_W(C)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (en[NS-1:5]),
    .num_i  (nx_q),
    .den_i  (zv5_q),
    .zero_i (zero5_q),
    .alt_i  (altx_q),
    .quo_o  (qx),
    .zero_o (zx)
  );

  ppp_divider #(.NUM_W(W_N), .DEN_W(W_V), .OUT_W(C)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (en[NS-1:5]),
    .num_i  (ny_q),
    .den_i  (zv5_q),
    .zero_i (zero5_q),
    .alt_i  (alty_q),
    .quo_o  (qy),
    .zero_o (zy)
  );

  assign out_o.valid      = v_q[NS-1];
  assign out_o.screen_x   = qx;
  assign out_o.screen_y   = qy;
  assign out_o.depth_zero = zx;

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !out_o.ready && v_q[NS-2] |=> v_q[NS-2])
    else $error("stalled stage dropped its item");

  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> !(&v_q) || out_o.ready)
    else $error("input taken into a full pipeline");

  a_zero_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> zx == zy)
    else $error("zero flag mismatch between dividers");

endmodule

>>> verif/tb_perspective_point_projector_unit.sv
// Testbench for perspective_point_projector_unit: directed table, then random phases.
// Results are checked against a built-in projection predictor and a register shadow.
// Depends on ppp_pkg, ppp_if and the unit RTL.
`timescale 1ns / 100ps

module tb_perspective_point_projector_unit;
  import ppp_pkg::*;

  localparam int CW         = COORD_BITS_DEF;
  localparam int FB         = TRIG_FRAC_BITS_DEF;
  localparam int CYCLE_CAP  = 600000;
  localparam int HOLD_LEN   = 300;
  localparam int PHASES     = 14;
  localparam int PHASE_PTS  = 125;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 dz;
  } screen_t;

  typedef enum logic {ROW_CFG, ROW_POINT} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic signed [CW-1:0]  px, py, pz;
    bit                    typed;
    screen_t               want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   errors = 0;
  bit   hold_req = 1'b0;
  bit   rx_no_gap = 1'b0;

  logic [CFG_DATA_W-1:0] cam_reg [8];
  screen_t               screen_q [$];
  plan_row_t             plan [$];

  ppp_cfg_if           cfg_ch ();
  ppp_in_if  #(CW)     in_ch  ();
  ppp_out_if #(CW)     out_ch ();

  perspective_point_projector_unit #(.COORD_BITS(CW), .TRIG_FRAC_BITS(FB)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic signed [CW-1:0] clamp(longint v);
    longint hi = (longint'(1) <<< (CW - 1)) - 1;
    longint lo = -(longint'(1) <<< (CW - 1));
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic screen_t project_point(logic signed [CW-1:0] px, py, pz);
    longint sa   = sx16(cam_reg[REG_SIN_AZ]);
    longint ca   = sx16(cam_reg[REG_COS_AZ]);
    longint se   = sx16(cam_reg[REG_SIN_EL]);
    longint ce   = sx16(cam_reg[REG_COS_EL]);
    longint rho  = longint'({48'd0, cam_reg[REG_EYE]});
    longint d    = longint'({52'd0, cam_reg[REG_PROJ][DIST_W-1:0]});
    longint offx = sx16(cam_reg[REG_OFF_X]);
    longint offy = sx16(cam_reg[REG_OFF_Y]);
    longint x    = longint'(px);
    longint y    = longint'(py);
    longint z    = longint'(pz);
    longint xv, yv, zv;
    screen_t r;
    xv = (-sa * x + ca * y) <<< FB;
    yv = -ce * ca * x - ce * sa * y + ((se * z) <<< FB);
    zv = -se * ca * x - se * sa * y - ((ce * z) <<< FB) + (rho <<< (2 * FB));
    if (zv == 0) begin
      r.sx = clamp(offx);
      r.sy = clamp(offy);
      r.dz = 1'b1;
    end else begin
      r.sx = clamp((d * xv + offx * zv) / zv);
      r.sy = clamp((d * yv + offy * zv) / zv);
      r.dz = 1'b0;
    end
    return r;
  endfunction

  function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, px: '0, py: '0, pz: '0, typed: 0, want: '0};
    plan.push_back(r);
  endfunction

  function automatic void pt_row(int x, int y, int z, bit typed = 0,
                                 int wx = 0, int wy = 0, bit wz = 0);
    plan_row_t r;
    r = '{kind: ROW_POINT, idx: '0, data: '0, px: x[CW-1:0], py: y[CW-1:0],
          pz: z[CW-1:0], typed: typed, want: '{wx[CW-1:0], wy[CW-1:0], wz}};
    plan.push_back(r);
  endfunction

  // leaves valid high; caller lowers it once the batch is done
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cam_reg[idx] = (idx == REG_PROJ) ? (data & 16'h0FFF) : data;
  endtask

  task automatic send_point(logic signed [CW-1:0] x, y, z, int gap,
                            bit typed = 0, screen_t want = '0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.point_z <= z;
    do @(posedge clk_i); while (!in_ch.ready);
    screen_q.push_back(typed ? want : project_point(x, y, z));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (screen_q.size() == 0);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return $signed(16'($urandom_range(0, 400))) - 16'sd200;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver
  initial begin
    int w;
    screen_t got, exp_r;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end
      w = rx_no_gap ? 0 : $urandom_range(0, 15);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got = '{out_ch.screen_x, out_ch.screen_y, out_ch.depth_zero};
      if (screen_q.size() == 0) begin
        $error("unexpected transaction: x=%0d y=%0d dz=%0b", got.sx, got.sy, got.dz);
        errors++;
      end else begin
        exp_r = screen_q.pop_front();
        if (got.sx !== exp_r.sx) begin
          $error("screen_x exp %0d got %0d", exp_r.sx, got.sx);
          errors++;
        end
        if (got.sy !== exp_r.sy) begin
          $error("screen_y exp %0d got %0d", exp_r.sy, got.sy);
          errors++;
        end
        if (got.dz !== exp_r.dz) begin
          $error("depth_zero exp %0b got %0b", exp_r.dz, got.dz);
          errors++;
        end
      end
    end
  end

  // sender and configuration
  initial begin
    int gap, mode;
    bit tx_no_gap;
    logic [CFG_DATA_W-1:0] v;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    cam_reg = '{RST_SIN_AZ, RST_COS_AZ, RST_SIN_EL, RST_COS_EL,
                RST_EYE, 16'(RST_PROJ), RST_OFF_X, RST_OFF_Y};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // origin at reset settings lands on the offsets
    pt_row(0, 0, 0, 1, 320, 320, 0);
    pt_row(32767, 32767, 32767);
    pt_row(-32768, -32768, -32768);
    pt_row(32767, -32768, 0);
    pt_row(0, 0, 3000);            // behind the eye
    pt_row(-500, 700, -32768);
    cfg_row(REG_EYE, 16'd0);
    pt_row(0, 0, 0, 1, 320, 320, 1);
    cfg_row(REG_OFF_X, 16'h7FFF);
    cfg_row(REG_OFF_Y, 16'h8000);
    pt_row(0, 0, 0, 1, 32767, -32768, 1);
    cfg_row(REG_SIN_AZ, 16'd0);
    cfg_row(REG_COS_AZ, 16'd0);
    cfg_row(REG_SIN_EL, 16'd0);
    cfg_row(REG_COS_EL, 16'd0);
    pt_row(32767, -32768, 12345, 1, 32767, -32768, 1);
    cfg_row(REG_SIN_AZ, 16'h8000);
    cfg_row(REG_COS_AZ, 16'h7FFF);
    cfg_row(REG_SIN_EL, 16'hC000);
    cfg_row(REG_COS_EL, 16'h4000);
    cfg_row(REG_EYE, 16'hFFFF);
    cfg_row(REG_PROJ, 16'hFFFF);
    pt_row(32767, 32767, -32768);
    pt_row(-32768, 1, 1);
    pt_row(1, 1, 1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (cfg_ch.valid) cfg_ch.valid <= 1'b0;
        send_point(plan[i].px, plan[i].py, plan[i].pz, $urandom_range(0, 3),
                   plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      mode = ph % 4;
      for (int r = 0; r < 8; r++) begin
        v = 16'($urandom);
        if (mode == 1) begin
          case (r)
            REG_EYE:  v = (ph & 4) ? 16'hFFFF : 16'h0000;
            REG_PROJ: v = (ph & 4) ? 16'h0FFF : 16'h0000;
            REG_OFF_X, REG_OFF_Y: v = (ph & 4) ? 16'h7FFF : 16'h8000;
            default:  v = (ph & 4) ? 16'd16384 : -16'sd16384;
          endcase
        end else if (mode == 2 && r < 4) begin
          v = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        end else if (mode == 3 && r == REG_EYE) begin
          v = 16'd0;
        end
        write_reg(r[CFG_IDX_W-1:0], v);
      end
      cfg_ch.valid <= 1'b0;

      tx_no_gap = (ph % 3 == 0);
      rx_no_gap = (ph % 5 == 1);
      if (ph == 2) begin
        tx_no_gap = 1'b1;
        rx_no_gap = 1'b0;
        hold_req  = 1'b1;
      end
      for (int k = 0; k < PHASE_PTS; k++) begin
        if (ph == 5 && k == 60) drain();
        gap = tx_no_gap ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 15) == 0)
          send_point('0, '0, '0, gap);
        else
          send_point(rand_coord(), rand_coord(), rand_coord(), gap);
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
